// File: rtl/assert_macros.svh
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: rtl/tkst_pkg.sv
// Package with types and constants of the top-k score tracker.
package tkst_pkg;
  localparam int unsigned DefCapacity = 64;

  localparam logic [2:0] StStored    = 3'd0;
  localparam logic [2:0] StReplaced  = 3'd1;
  localparam logic [2:0] StDiscarded = 3'd2;
  localparam logic [2:0] StList      = 3'd3;
  localparam logic [2:0] StEmpty     = 3'd4;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqDrain  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        entry_uid;
    logic signed [31:0] entry_score;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        out_uid;
    logic signed [31:0] out_score;
    logic [6:0]         held_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [31:0]        uid;
    logic signed [31:0] score;
  } entry_t;
endpackage

// File: rtl/top_k_score_tracker.sv
// Top-k score tracker: a min-heap in block memory with a sequencer for sift and drain.
// Insert below capacity: the entry sifts up via S_UPRD and S_UPCMP per level; the result is
//   registered when the sift stops, and busy drops in the result cycle.
// Full heap: a discard answers after the root read, without a sift; a replace sifts down via
//   S_DNRD, S_DNL and S_DNCMP per level, then gives its result.
// Drain: copy to the scratch heap, heap sort (S_SWRD, S_SWWR, sift down per removal), then one
//   listed entry per cycle; the receiver cannot stall. Reset empties the heap (fill count zero).
`include "assert_macros.svh"
module top_k_score_tracker
  import tkst_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_UPRD  = 11'b00000000010,
    S_UPCMP = 11'b00000000100,
    S_DNRD  = 11'b00000001000,
    S_DNL   = 11'b00000010000,
    S_DNCMP = 11'b00000100000,
    S_CPRD  = 11'b00001000000,
    S_SWRD  = 11'b00010000000,
    S_SWWR  = 11'b00100000000,
    S_LSRD  = 11'b01000000000,
    S_LSOUT = 11'b10000000000
  } state_t;

  state_t state;
  entry_t heap_mem [CAPACITY];
  entry_t scr_mem  [CAPACITY];

  logic [CW-1:0] fill;
  logic [AW-1:0] pos;
  logic [AW:0]   lim;
  logic [CW-1:0] m;
  logic [CW-1:0] idx;
  logic          on_scr;
  logic          drain_mode;
  entry_t        cur;
  entry_t        lch;
  entry_t        rd_h;
  entry_t        rd_s;
  logic [AW-1:0] h_ra, s_ra;
  logic [AW-1:0] h_wa, s_wa;
  logic          h_we, s_we;
  entry_t        h_wd, s_wd;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    rd_h <= heap_mem[h_ra];
  end
  always_ff @(posedge clk) begin
    if (s_we) scr_mem[s_wa] <= s_wd;
    rd_s <= scr_mem[s_ra];
  end

  entry_t rd;
  assign rd = on_scr ? rd_s : rd_h;

  function automatic logic [31:0] key(entry_t e);
    return {~e.score[31], e.score[30:0]};
  endfunction

  logic [AW:0] lft, rgt;
  logic [AW:0] parent;
  assign lft    = {pos, 1'b1};
  assign rgt    = {pos, 1'b1} + (AW+1)'(1);
  assign parent = (AW+1)'((pos - AW'(1)) >> 1);

  logic   r_ok;
  logic   take_r;
  entry_t ch;
  logic [AW-1:0] ch_a;
  assign r_ok   = rgt < lim;
  assign take_r = r_ok && (key(rd) <= key(lch));
  assign ch     = take_r ? rd : lch;
  assign ch_a   = take_r ? rgt[AW-1:0] : lft[AW-1:0];

  logic up_move, dn_move, discard;
  assign up_move = (pos != '0) && (key(cur) < key(rd));
  assign dn_move = (lft < lim) && (key(cur) > key(ch));
  // On a full heap the first read after the transfer returns the root.
  assign discard = !drain_mode && (pos == '0) && (key(cur) <= key(rd));

  // Root of the scratch heap, kept in a register during the sort.
  entry_t root;

  always_comb begin
    h_ra = '0; s_ra = '0;
    h_we = 1'b0; s_we = 1'b0;
    h_wa = pos; s_wa = pos;
    h_wd = cur; s_wd = cur;
    unique case (state)
      S_IDLE: begin
        h_ra = '0;
        if (start && req.req_type == ReqInsert) begin
          if (fill < CW'(CAPACITY)) begin
            h_ra = AW'((fill - CW'(1)) >> 1);
          end
        end
      end
      S_UPRD:  h_ra = parent[AW-1:0];
      S_UPCMP: begin
        if (up_move) begin
          h_we = 1'b1; h_wa = pos; h_wd = rd;
        end else begin
          h_we = 1'b1; h_wa = pos; h_wd = cur;
        end
      end
      S_DNRD: begin
        h_ra = lft[AW-1:0]; s_ra = lft[AW-1:0];
      end
      S_DNL: begin
        h_ra = rgt[AW-1:0]; s_ra = rgt[AW-1:0];
      end
      S_DNCMP: begin
        if (dn_move) begin
          if (on_scr) begin s_we = 1'b1; s_wd = ch; end
          else begin h_we = 1'b1; h_wd = ch; end
        end else begin
          if (on_scr) begin s_we = 1'b1; s_wd = cur; end
          else begin h_we = 1'b1; h_wd = cur; end
        end
      end
      S_CPRD: begin
        h_ra = idx[AW-1:0];
        s_we = idx != '0;
        s_wa = AW'(idx - CW'(1));
        s_wd = rd_h;
      end
      S_SWRD: s_ra = AW'(m - CW'(1));
      S_SWWR: begin
        s_we = 1'b1; s_wa = AW'(m - CW'(1)); s_wd = root;
      end
      S_LSRD:  s_ra = idx[AW-1:0];
      S_LSOUT: s_ra = AW'(idx + CW'(1));
      default: ;
    endcase
  end

  logic done_next;

  always_comb begin
    done_next = 1'b0;
    unique case (state)
      S_IDLE:  done_next = start && req.req_type == ReqDrain && fill == '0;
      S_UPCMP: done_next = !up_move;
      S_DNRD:  done_next = discard;
      S_DNCMP: done_next = !dn_move && !drain_mode;
      S_LSOUT: done_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= done_next;
      if (s_we && s_wa == '0) root <= s_wd;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur <= '{uid: req.entry_uid, score: req.entry_score};
            if (req.req_type == ReqInsert) begin
              on_scr <= 1'b0;
              drain_mode <= 1'b0;
              if (fill < CW'(CAPACITY)) begin
                pos <= AW'(fill);
                fill <= fill + CW'(1);
                state <= S_UPCMP;
              end else begin
                state <= S_DNRD;
                pos <= '0;
                lim <= (AW+1)'(CAPACITY);
              end
            end else if (fill == '0) begin
              result <= '{status: StEmpty, out_uid: '0, out_score: '0,
                          held_count: '0, last: 1'b1};
            end else begin
              drain_mode <= 1'b1;
              on_scr <= 1'b1;
              idx <= '0;
              state <= S_CPRD;
            end
          end
        end
        S_UPRD: state <= S_UPCMP;
        S_UPCMP: begin
          if (up_move) begin
            pos <= parent[AW-1:0];
            state <= S_UPRD;
          end else begin
            result <= '{status: StStored, out_uid: '0, out_score: '0,
                        held_count: 7'(fill), last: 1'b1};
            state <= S_IDLE;
          end
        end
        S_DNRD: begin
          if (discard) begin
            result <= '{status: StDiscarded, out_uid: '0, out_score: '0,
                        held_count: 7'(fill), last: 1'b1};
            state <= S_IDLE;
          end else if (lft >= lim) begin
            state <= S_DNCMP;
          end else begin
            state <= S_DNL;
          end
        end
        S_DNL: begin
          lch <= rd;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (dn_move) begin
            pos <= ch_a;
            state <= S_DNRD;
          end else if (drain_mode) begin
            state <= (m > CW'(1)) ? S_SWRD : S_LSRD;
            m <= m - CW'(1);
            idx <= '0;
          end else begin
            result <= '{status: StReplaced, out_uid: '0, out_score: '0,
                        held_count: 7'(fill), last: 1'b1};
            state <= S_IDLE;
          end
        end
        S_CPRD: begin
          idx <= idx + CW'(1);
          if (idx == fill) begin
            m <= fill;
            state <= S_SWRD;
          end
        end
        S_SWRD: state <= S_SWWR;
        S_SWWR: begin
          // Slot m-1 gets the root; the old last entry restarts at the root.
          cur <= rd_s;
          state <= S_DNRD;
          pos <= '0;
          lim <= (AW+1)'(m - CW'(1));
        end
        S_LSRD: state <= S_LSOUT;
        S_LSOUT: begin
          result <= '{status: StList, out_uid: rd_s.uid, out_score: rd_s.score,
                      held_count: 7'(fill), last: (idx + CW'(1) == fill)};
          idx <= idx + CW'(1);
          if (idx + CW'(1) == fill) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `ASSERT_NEVER(a_fill_range, clk, rst, fill > CW'(CAPACITY))
  `ASSERT_IMPL(a_done_idle, clk, rst, (done && result.last) |-> !busy)
  `ASSERT_IMPL(a_start_busy, clk, rst, (start && !busy && req.req_type == ReqInsert) |=> (busy || done))
endmodule

// File: dv/tb_top_k_score_tracker.sv
// Testbench for the top-k score tracker: directed and random requests checked against a heap predictor.
module tb_top_k_score_tracker
  import tkst_pkg::*;
;

  localparam int Cap = DefCapacity;
  localparam int IdleLimit = 20000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  req_t    req = '0;
  logic    done;
  result_t result;

  top_k_score_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_t    pending_reqs[$];
  result_t expected_results[$];
  entry_t  heap_img[Cap];
  int      fill_cnt = 0;
  int      idle_pct = 0;
  int      errors = 0;
  int      idle_cycles = 0;
  int      n_inserts = 0, n_drains = 0, n_results = 0;
  logic    took = 1'b0;

  function automatic void sift_down(inout entry_t a[Cap], input int n);
    int pos, l, c;
    entry_t t;
    pos = 0;
    forever begin
      l = 2 * pos + 1;
      if (l >= n) break;
      c = l;
      if (l + 1 < n && a[l+1].score <= a[l].score) c = l + 1;
      if (a[pos].score > a[c].score) begin
        t = a[pos]; a[pos] = a[c]; a[c] = t;
        pos = c;
      end else begin
        break;
      end
    end
  endfunction

  // Updates the heap image and queues the results that one request produces.
  function automatic void predict_request(req_t r);
    result_t res;
    entry_t  e, t;
    entry_t  work[Cap];
    int      pos, par;
    res = '0;
    res.last = 1'b1;
    e.uid = r.entry_uid;
    e.score = r.entry_score;
    if (r.req_type == ReqInsert) begin
      if (fill_cnt < Cap) begin
        heap_img[fill_cnt] = e;
        pos = fill_cnt;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (heap_img[pos].score < heap_img[par].score) begin
            t = heap_img[pos]; heap_img[pos] = heap_img[par]; heap_img[par] = t;
            pos = par;
          end else begin
            break;
          end
        end
        fill_cnt++;
        res.status = StStored;
      end else if (e.score <= heap_img[0].score) begin
        res.status = StDiscarded;
      end else begin
        heap_img[0] = e;
        sift_down(heap_img, fill_cnt);
        res.status = StReplaced;
      end
      res.held_count = 7'(fill_cnt);
      expected_results.push_back(res);
    end else if (fill_cnt == 0) begin
      res.status = StEmpty;
      expected_results.push_back(res);
    end else begin
      work = heap_img;
      for (int m = fill_cnt; m > 0; m--) begin
        t = work[0]; work[0] = work[m-1]; work[m-1] = t;
        sift_down(work, m - 1);
      end
      for (int i = 0; i < fill_cnt; i++) begin
        res.status = StList;
        res.out_uid = work[i].uid;
        res.out_score = work[i].score;
        res.held_count = 7'(fill_cnt);
        res.last = (i + 1 == fill_cnt);
        expected_results.push_back(res);
      end
    end
  endfunction

  // Driver: a new request is presented once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst && (took || !start)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are checked before a transfer on the same edge is predicted.
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, exp none act %h", $time, result);
          errors++;
        end else begin
          result_t ex;
          ex = expected_results.pop_front();
          if (result.status !== ex.status || result.out_uid !== ex.out_uid ||
              result.out_score !== ex.out_score || result.held_count !== ex.held_count ||
              result.last !== ex.last) begin
            $display("%0t: result mismatch, exp %h act %h", $time, ex, result);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predict_request(req);
        if (req.req_type == ReqInsert) n_inserts++;
        else n_drains++;
      end
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("top_k_score_tracker test failed");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic kind, logic [31:0] uid, logic [31:0] score);
    req_t r;
    r.req_type = kind;
    r.entry_uid = uid;
    r.entry_score = score;
    return r;
  endfunction

  function automatic logic [31:0] pick_score();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(15)) - 8);
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(int pct, int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(13) == 0) pending_reqs.push_back(make_req(ReqDrain, $urandom, $urandom));
      else pending_reqs.push_back(make_req(ReqInsert, $urandom, pick_score()));
    end
    wait (pending_reqs.size() == 0 && !start && expected_results.size() == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Empty drain, field extremes, ties and a short sorted listing.
    pending_reqs.push_back(make_req(ReqDrain, 32'hffffffff, 32'h7fffffff));
    pending_reqs.push_back(make_req(ReqInsert, 32'h0, 32'h80000000));
    pending_reqs.push_back(make_req(ReqInsert, 32'hffffffff, 32'h7fffffff));
    pending_reqs.push_back(make_req(ReqInsert, 32'h12345678, 32'h0));
    pending_reqs.push_back(make_req(ReqInsert, 32'haaaaaaaa, 32'hffffffff));
    pending_reqs.push_back(make_req(ReqInsert, 32'h55555555, 32'h0));
    pending_reqs.push_back(make_req(ReqInsert, 32'h0f0f0f0f, 32'h0));
    pending_reqs.push_back(make_req(ReqDrain, 32'h0, 32'h0));
    pending_reqs.push_back(make_req(ReqInsert, 32'h00000001, 32'h00000001));
    pending_reqs.push_back(make_req(ReqDrain, 32'h0, 32'h0));
    wait (pending_reqs.size() == 0 && !start && expected_results.size() == 0);
    run_phase(0, 120);
    run_phase(79, 110);
    run_phase(17, 110);
    run_phase(0, 100);
    pending_reqs.push_back(make_req(ReqDrain, 32'h0, 32'h0));
    wait (pending_reqs.size() == 0 && !start && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d inserts and %0d drains, %0d results checked; final fill %0d.",
             n_inserts, n_drains, n_results, fill_cnt);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("top_k_score_tracker test passed");
    end else begin
      $display("top_k_score_tracker test failed");
    end
    $finish;
  end
endmodule
